### hdl/lfs_pkg.sv
package lfs_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned SPEED_W = 8;
    localparam int unsigned MS_W    = 16;
    localparam int unsigned LAPS_W  = 8;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_STRAIGHT_SPEED    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_SPEED        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_TURN_FWD    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_TURN_BACK   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SMOOTH_FWD  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SMOOTH_BACK = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_WINDOW_MS  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_START_BLOCK_MS    = 3'd7;

    // Heading hint codes.
    localparam logic [1:0] HEAD_NONE  = 2'd0;
    localparam logic [1:0] HEAD_LEFT  = 2'd1;
    localparam logic [1:0] HEAD_RIGHT = 2'd2;

    localparam logic [LAPS_W-1:0] LAPS_MAX = '1;

    typedef enum logic [2:0] {
        LS_NOT_FOUND = 3'd0,
        LS_FWD       = 3'd1,
        LS_FWD_ML    = 3'd2,
        LS_FWD_MR    = 3'd3,
        LS_TURN_L    = 3'd4,
        LS_TURN_R    = 3'd5
    } t_line_state;

    typedef struct packed {
        logic [SPEED_W-1:0] straight_speed;
        logic [SPEED_W-1:0] slow_speed;
        logic [SPEED_W-1:0] speed_turn_fwd;
        logic [SPEED_W-1:0] speed_turn_back;
        logic [SPEED_W-1:0] speed_smooth_fwd;
        logic [SPEED_W-1:0] speed_smooth_back;
        logic [MS_W-1:0]    smooth_window_ms;
        logic [MS_W-1:0]    start_block_ms;
    } t_cfg;

    typedef struct packed {
        logic              sensor_left;
        logic              sensor_mid;
        logic              sensor_right;
        logic [TIME_W-1:0] now_ms;
        logic              heading_update_en;
        logic              homing_mode;
    } t_sample;

    typedef struct packed {
        logic               left_backward;
        logic [SPEED_W-1:0] left_speed;
        logic               right_backward;
        logic [SPEED_W-1:0] right_speed;
        logic [1:0]         heading_hint;
        logic [LAPS_W-1:0]  lap_count;
        logic               run_finished;
        logic               home_reached;
        logic               led_update;
    } t_result;

endpackage

### hdl/line_follower_steering_fsm_top.sv
// Line follower steering controller. Each request carries one sample of the
// left, middle and right line sensors with the current millisecond time and
// yields one result: both motor directions and speeds, the heading hint, the
// lap count, run-finished, home-reached and an LED update flag. A request is
// registered on entry, processed by one level of compare-and-select logic and
// the result is held in an output register, so the block accepts one request
// every clock cycle unless the output stalls; a result passes the input
// register and then the output register, which lets a new request enter
// while a result waits to be taken. The user must write configuration
// registers via i_cfg_we only while no request is in flight; not enforced.
module line_follower_steering_fsm_top
    import lfs_pkg::*;
#(
    parameter int unsigned DIR_UPDATE_MS = 100,
    parameter int unsigned LAP_LIMIT     = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_sensor_left,
    input  logic                  i_sensor_mid,
    input  logic                  i_sensor_right,
    input  logic [TIME_W-1:0]     i_now_ms,
    input  logic                  i_heading_update_en,
    input  logic                  i_homing_mode,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_left_backward,
    output logic [SPEED_W-1:0]    o_left_speed,
    output logic                  o_right_backward,
    output logic [SPEED_W-1:0]    o_right_speed,
    output logic [1:0]            o_heading_hint,
    output logic [LAPS_W-1:0]     o_lap_count,
    output logic                  o_run_finished,
    output logic                  o_home_reached,
    output logic                  o_led_update,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    r_cfg;
    t_sample r_sample;
    logic    r_in_valid;
    t_result r_result;
    logic    r_out_valid;
    t_result core_result;
    logic    advance;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.straight_speed    <= SPEED_W'(200);
            r_cfg.slow_speed        <= SPEED_W'(120);
            r_cfg.speed_turn_fwd    <= SPEED_W'(180);
            r_cfg.speed_turn_back   <= SPEED_W'(180);
            r_cfg.speed_smooth_fwd  <= SPEED_W'(150);
            r_cfg.speed_smooth_back <= SPEED_W'(50);
            r_cfg.smooth_window_ms  <= MS_W'(300);
            r_cfg.start_block_ms    <= MS_W'(200);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_STRAIGHT_SPEED:    r_cfg.straight_speed    <= i_cfg_data[SPEED_W-1:0];
                CFG_SLOW_SPEED:        r_cfg.slow_speed        <= i_cfg_data[SPEED_W-1:0];
                CFG_SPEED_TURN_FWD:    r_cfg.speed_turn_fwd    <= i_cfg_data[SPEED_W-1:0];
                CFG_SPEED_TURN_BACK:   r_cfg.speed_turn_back   <= i_cfg_data[SPEED_W-1:0];
                CFG_SPEED_SMOOTH_FWD:  r_cfg.speed_smooth_fwd  <= i_cfg_data[SPEED_W-1:0];
                CFG_SPEED_SMOOTH_BACK: r_cfg.speed_smooth_back <= i_cfg_data[SPEED_W-1:0];
                CFG_SMOOTH_WINDOW_MS:  r_cfg.smooth_window_ms  <= i_cfg_data[MS_W-1:0];
                CFG_START_BLOCK_MS:    r_cfg.start_block_ms    <= i_cfg_data[MS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_sample.sensor_left       <= i_sensor_left;
            r_sample.sensor_mid        <= i_sensor_mid;
            r_sample.sensor_right      <= i_sensor_right;
            r_sample.now_ms            <= i_now_ms;
            r_sample.heading_update_en <= i_heading_update_en;
            r_sample.homing_mode       <= i_homing_mode;
        end
        if (advance) begin
            r_result <= core_result;
        end
    end

    lfs_core #(
        .DIR_UPDATE_MS (DIR_UPDATE_MS),
        .LAP_LIMIT     (LAP_LIMIT)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_sample (r_sample),
        .i_cfg    (r_cfg),
        .o_result (core_result)
    );

    assign o_out_valid      = r_out_valid;
    assign o_left_backward  = r_result.left_backward;
    assign o_left_speed     = r_result.left_speed;
    assign o_right_backward = r_result.right_backward;
    assign o_right_speed    = r_result.right_speed;
    assign o_heading_hint   = r_result.heading_hint;
    assign o_lap_count      = r_result.lap_count;
    assign o_run_finished   = r_result.run_finished;
    assign o_home_reached   = r_result.home_reached;
    assign o_led_update     = r_result.led_update;

endmodule

### hdl/lfs_core.sv
module lfs_core
    import lfs_pkg::*;
#(
    parameter int unsigned DIR_UPDATE_MS = 100,
    parameter int unsigned LAP_LIMIT     = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_sample i_sample,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    t_line_state r_line_state, n_line_state;
    logic [2:0]        r_prev_sensors;
    logic              r_smooth_active, n_smooth_active;
    logic [TIME_W-1:0] r_smooth_start_ms, n_smooth_start_ms;
    logic [TIME_W-1:0] r_dir_update_ms, n_dir_update_ms;
    logic [1:0]        r_heading, n_heading;
    logic              r_start_armed, n_start_armed;
    logic              r_start_seen, n_start_seen;
    logic [TIME_W-1:0] r_start_seen_ms, n_start_seen_ms;
    logic [LAPS_W-1:0] r_laps, n_laps;

    logic [2:0]        pattern;
    logic              all_on;
    logic              home;
    logic              seen_mid;
    logic [TIME_W-1:0] now;
    logic              to_left;
    logic              in_window;
    logic              dir_due;

    assign now     = i_sample.now_ms;
    assign pattern = {i_sample.sensor_left, i_sample.sensor_mid, i_sample.sensor_right};
    assign all_on  = &pattern;

    // Start-block detector: all sensors held on line long enough counts a lap, or flags home in homing mode.
    always_comb begin
        n_start_seen    = r_start_seen;
        n_start_armed   = r_start_armed;
        n_start_seen_ms = r_start_seen_ms;
        n_laps          = r_laps;
        home            = 1'b0;
        if (all_on && !r_start_seen && r_start_armed) begin
            n_start_seen    = 1'b1;
            n_start_armed   = 1'b0;
            n_start_seen_ms = now;
        end else if (!all_on) begin
            n_start_seen  = 1'b0;
            n_start_armed = 1'b1;
        end
        seen_mid = n_start_seen;
        if (seen_mid && ((now - n_start_seen_ms) >= TIME_W'(i_cfg.start_block_ms))) begin
            if (i_sample.homing_mode) begin
                home = 1'b1;
            end else if (r_laps != LAPS_MAX) begin
                n_laps = r_laps + LAPS_W'(1);
            end
            n_start_seen = 1'b0;
        end
    end

    // Steering state: next state.
    always_comb begin
        n_line_state = r_line_state;
        if (i_sample.sensor_mid && i_sample.sensor_left) begin
            n_line_state = LS_FWD_ML;
        end else if (i_sample.sensor_mid && i_sample.sensor_right) begin
            n_line_state = LS_FWD_MR;
        end else if (i_sample.sensor_mid) begin
            if (r_line_state == LS_FWD_ML || r_line_state == LS_FWD_MR) begin
                n_line_state = r_line_state;
            end else begin
                n_line_state = LS_FWD;
            end
        end else if (i_sample.sensor_left) begin
            n_line_state = LS_TURN_L;
        end else if (i_sample.sensor_right) begin
            n_line_state = LS_TURN_R;
        end else if (r_line_state == LS_FWD_ML) begin
            n_line_state = LS_TURN_L;
        end else if (r_line_state == LS_FWD_MR) begin
            n_line_state = LS_TURN_R;
        end
    end

    assign to_left   = (n_line_state == LS_TURN_L);
    assign in_window = (now - r_smooth_start_ms) < TIME_W'(i_cfg.smooth_window_ms);
    assign dir_due   = ((now - r_dir_update_ms) >= TIME_W'(DIR_UPDATE_MS))
                       && i_sample.heading_update_en;

    // Steering state: motor outputs, turn timers, heading hint and status flags.
    always_comb begin
        n_smooth_active   = r_smooth_active;
        n_smooth_start_ms = r_smooth_start_ms;
        n_dir_update_ms   = r_dir_update_ms;
        n_heading         = r_heading;
        o_result          = '0;
        case (n_line_state)
            LS_TURN_L, LS_TURN_R: begin
                if (dir_due) begin
                    n_dir_update_ms = now;
                    n_heading       = to_left ? HEAD_LEFT : HEAD_RIGHT;
                end
                if (in_window) begin
                    if (!r_smooth_active) begin
                        n_smooth_active   = 1'b1;
                        n_smooth_start_ms = now;
                    end
                    n_dir_update_ms = now;
                    o_result.left_backward  = to_left;
                    o_result.right_backward = !to_left;
                    o_result.left_speed  = to_left ? i_cfg.speed_smooth_back
                                                   : i_cfg.speed_smooth_fwd;
                    o_result.right_speed = to_left ? i_cfg.speed_smooth_fwd
                                                   : i_cfg.speed_smooth_back;
                end else begin
                    n_smooth_active = 1'b0;
                    o_result.left_backward  = to_left;
                    o_result.right_backward = !to_left;
                    o_result.left_speed  = to_left ? i_cfg.speed_turn_back
                                                   : i_cfg.speed_turn_fwd;
                    o_result.right_speed = to_left ? i_cfg.speed_turn_fwd
                                                   : i_cfg.speed_turn_back;
                end
            end
            default: begin
                n_smooth_start_ms = now;
                n_dir_update_ms   = now;
                o_result.left_speed  = all_on ? i_cfg.slow_speed : i_cfg.straight_speed;
                o_result.right_speed = all_on ? i_cfg.slow_speed : i_cfg.straight_speed;
            end
        endcase
        o_result.heading_hint = n_heading;
        o_result.lap_count    = n_laps;
        o_result.run_finished = (n_laps >= LAPS_W'(LAP_LIMIT));
        o_result.home_reached = home;
        o_result.led_update   = (pattern != r_prev_sensors);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_state      <= LS_NOT_FOUND;
            r_prev_sensors    <= '0;
            r_smooth_active   <= 1'b0;
            r_smooth_start_ms <= '0;
            r_dir_update_ms   <= '0;
            r_heading         <= HEAD_NONE;
            r_start_armed     <= 1'b1;
            r_start_seen      <= 1'b0;
            r_start_seen_ms   <= '0;
            r_laps            <= '0;
        end else if (i_step) begin
            r_line_state      <= n_line_state;
            r_prev_sensors    <= pattern;
            r_smooth_active   <= n_smooth_active;
            r_smooth_start_ms <= n_smooth_start_ms;
            r_dir_update_ms   <= n_dir_update_ms;
            r_heading         <= n_heading;
            r_start_armed     <= n_start_armed;
            r_start_seen      <= n_start_seen;
            r_start_seen_ms   <= n_start_seen_ms;
            r_laps            <= n_laps;
        end
    end

endmodule
